>>> rtl/nrv2_pkg.sv
// Package: shared types and constants of the NRV2 decompressor.
package nrv2_pkg;

    typedef enum logic [4:0] {
        PH_TOP, PH_LIT, PH_OFFA, PH_OFFB, PH_OFFC, PH_OFFBYTE, PH_LEN1, PH_LEN2,
        PH_GAMA, PH_GAMB, PH_ESEL, PH_EONE, PH_ETWO, PH_ETHREE, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_RD, S_FIN, S_EMRD, S_EMWR
    } t_bstate;

    localparam logic       OP_FEED = 1'b0;
    localparam logic       OP_CONT = 1'b1;

    localparam logic [1:0] V_2B = 2'd0;
    localparam logic [1:0] V_2D = 2'd1;
    localparam logic [1:0] V_2E = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TRUNC = 3'd1;
    localparam logic [2:0] ERR_BADOF = 3'd2;
    localparam logic [2:0] ERR_LIMIT = 3'd3;
    localparam logic [2:0] ERR_OVF   = 3'd4;
    localparam logic [2:0] ERR_WIN   = 3'd5;

    localparam logic       CFG_VARIANT = 1'b0;
    localparam logic       CFG_LIMIT   = 1'b1;

    localparam logic [31:0] OFF_MAX     = 32'h3fffffff;
    localparam logic [31:0] LEN_MAX     = 32'h7fffffff;
    localparam logic [31:0] THR_B       = 32'hfffff300;
    localparam logic [31:0] THR_DE      = 32'hfffffb00;
    localparam logic [31:0] ALL_ONES    = 32'hffffffff;
    localparam logic [31:0] OFF_HI_MASK = 32'hff000000;
    localparam logic [31:0] LIMIT_RST   = 32'd65536;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  variant;
        logic [31:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_data;
        logic        run_end;
        logic        copy_pending;
        logic        finished;
        logic [2:0]  error_code;
        logic [31:0] bytes_out;
    } t_result;

endpackage

>>> rtl/nrv2_ifs.sv
// Interfaces: request channel and result channel.
interface nrv2_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] in_byte;
    logic       final_byte;
    modport source(output valid, opcode, in_byte, final_byte, input ready);
    modport sink(input valid, opcode, in_byte, final_byte, output ready);
endinterface

interface nrv2_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_data;
    logic        run_end;
    logic        copy_pending;
    logic        finished;
    logic [2:0]  error_code;
    logic [31:0] bytes_out;
    modport source(output valid, out_byte, has_data, run_end, copy_pending, finished,
                   error_code, bytes_out, input ready);
    modport sink(input valid, out_byte, has_data, run_end, copy_pending, finished,
                 error_code, bytes_out, output ready);
endinterface

>>> rtl/nrv2_lz_decompressor_top.sv
// Top level: NRV2 2B/2D/2E decompressor with config registers, queue and engine.
// Each request passes the queue and is then accepted by the engine, which decodes
// flag bits, finishes match codes, copies each match byte (history read, then
// write) and stops; results leave one at a time and stall on o_rsp.ready.
// Synchronous active-low reset clears control state; the history window is
// not cleared and holds no valid bits.
module nrv2_lz_decompressor_top
    import nrv2_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536,
    parameter int BURST_MAX    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrv2_req_if.sink    i_req,
    nrv2_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    t_cfg    r_cfg;
    t_item   in_item, q_item;
    logic    q_valid, q_ready;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variant <= V_2B;
            r_cfg.limit   <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VARIANT: r_cfg.variant <= i_cfg_data[1:0];
                CFG_LIMIT:   r_cfg.limit   <= i_cfg_data;
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    assign in_item.opcode     = i_req.opcode;
    assign in_item.in_byte    = i_req.in_byte;
    assign in_item.final_byte = i_req.final_byte;

    nrv2_fe u_fe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    nrv2_be #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .BURST_MAX    (BURST_MAX)
    ) u_be (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_res   (res)
    );

    assign o_rsp.out_byte     = res.out_byte;
    assign o_rsp.has_data     = res.has_data;
    assign o_rsp.run_end      = res.run_end;
    assign o_rsp.copy_pending = res.copy_pending;
    assign o_rsp.finished     = res.finished;
    assign o_rsp.error_code   = res.error_code;
    assign o_rsp.bytes_out    = res.bytes_out;
endmodule

>>> rtl/nrv2_fe.sv
// Front end: accepts requests into a two-entry queue for the decode engine.
module nrv2_fe
    import nrv2_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/nrv2_be.sv
// Back end: bit decoder, match copier with history window, burst result emitter.
module nrv2_be
    import nrv2_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536,
    parameter int BURST_MAX    = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int BW = (BURST_MAX > 1) ? $clog2(BURST_MAX) : 1;
    localparam int CW = $clog2(BURST_MAX + 1);
    localparam logic [AW-1:0] WLAST = AW'(WINDOW_BYTES - 1);
    localparam logic [AW:0]   WFULL = (AW + 1)'(WINDOW_BYTES);
    localparam logic [31:0]   WIN32 = 32'(WINDOW_BYTES);
    localparam logic [CW-1:0] BMAX  = CW'(BURST_MAX);

    t_bstate     r_st, n_st;
    t_phase      r_phase, n_phase;
    logic [31:0] r_fw, n_fw, r_wg, n_wg;
    logic [2:0]  r_gc, n_gc;
    logic [31:0] r_off, n_off, r_len, n_len, r_last, n_last;
    logic [31:0] r_copy, n_copy, r_cnt, n_cnt, r_fin, n_fin;
    logic [2:0]  r_err, n_err;
    logic        r_ended, n_ended;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [CW-1:0] r_bn, n_bn, r_k, n_k;
    logic        r_ov, n_ov;
    t_result     r_o, n_o;

    logic [7:0]  r_hist [WINDOW_BYTES];
    logic [7:0]  r_hq;
    logic [7:0]  r_buf [BURST_MAX];
    logic [7:0]  r_bq;

    logic        do_put, hist_re, buf_re, have_bit, b;
    logic [7:0]  put_d;
    logic [AW-1:0] hist_ra;
    logic [AW:0]   diff;
    logic [31:0] mdist, x, nx, offm3, thr;
    logic [33:0] tot;
    logic        is_de, is_e;
    logic [CW-1:0] nres;

    assign is_de   = (i_cfg.variant == V_2D) || (i_cfg.variant == V_2E);
    assign is_e    = (i_cfg.variant == V_2E);
    assign thr     = is_de ? THR_DE : THR_B;
    assign mdist   = 32'd0 - r_last;
    assign diff    = {1'b0, r_wptr} - mdist[AW:0];
    assign offm3   = r_off - 32'd3;
    assign x       = {offm3[23:0], i_item.in_byte};
    assign nx      = ~x;
    assign tot     = 34'(r_fin) + 34'(r_last < thr) + (is_e ? 34'd2 : 34'd1);
    assign nres    = (r_bn != '0) ? r_bn : CW'(1);
    assign o_valid = r_ov;
    assign o_res   = r_o;

    always_comb begin
        if (diff[AW]) begin
            hist_ra = AW'(diff + WFULL);
        end else begin
            hist_ra = diff[AW-1:0];
        end
    end

    always_comb begin
        n_st = r_st; n_phase = r_phase; n_fw = r_fw; n_wg = r_wg; n_gc = r_gc;
        n_off = r_off; n_len = r_len; n_last = r_last; n_copy = r_copy;
        n_cnt = r_cnt; n_fin = r_fin; n_err = r_err; n_ended = r_ended;
        n_wptr = r_wptr; n_bn = r_bn; n_k = r_k;
        n_ov = r_ov && !i_ready;
        n_o = r_o;
        o_ready = 1'b0;
        do_put = 1'b0; put_d = i_item.in_byte;
        hist_re = 1'b0; buf_re = 1'b0;
        have_bit = 1'b0; b = 1'b0;
        case (r_st)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_bn = '0;
                    n_k = '0;
                    n_st = S_EMRD;
                    if (r_err == ERR_NONE && r_phase != PH_DONE) begin
                        if (i_item.opcode == OP_FEED) begin
                            if (!r_ended && r_copy == 32'd0) begin
                                case (r_phase)
                                    PH_LIT: begin
                                        do_put = 1'b1;
                                        n_phase = PH_TOP;
                                    end
                                    PH_OFFBYTE: begin
                                        if (x == ALL_ONES) begin
                                            n_phase = PH_DONE;
                                        end else if (is_de) begin
                                            n_len = {31'd0, nx[0]};
                                            n_last = {nx[31], nx[31:1]};
                                            if (!is_e) begin
                                                n_phase = PH_LEN2;
                                            end else if (nx[0]) begin
                                                n_phase = PH_EONE;
                                            end else begin
                                                n_len = 32'd1;
                                                n_phase = PH_ETWO;
                                            end
                                        end else begin
                                            n_last = nx;
                                            n_phase = PH_LEN1;
                                        end
                                    end
                                    default: begin
                                        if (r_gc < 3'd4) begin
                                            n_wg = r_wg | (32'(i_item.in_byte)
                                                           << {r_gc[1:0], 3'b000});
                                            n_gc = r_gc + 3'd1;
                                        end
                                    end
                                endcase
                                if (i_item.final_byte) begin
                                    n_ended = 1'b1;
                                end
                                n_st = S_RUN;
                            end
                        end else if (r_copy != 32'd0) begin
                            n_st = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (r_err != ERR_NONE || r_phase == PH_DONE) begin
                    n_st = S_EMRD;
                end else if (r_copy != 32'd0) begin
                    if (r_bn >= BMAX) begin
                        n_st = S_EMRD;
                    end else begin
                        hist_re = 1'b1;
                        n_st = S_RD;
                    end
                end else if (r_phase == PH_LIT || r_phase == PH_OFFBYTE) begin
                    if (r_ended) begin
                        n_err = ERR_TRUNC;
                    end
                    n_st = S_EMRD;
                end else if (r_fw[30:0] == 31'd0) begin
                    if (r_gc < 3'd4) begin
                        if (r_ended) begin
                            n_err = ERR_TRUNC;
                        end
                        n_st = S_EMRD;
                    end else begin
                        b = r_wg[31];
                        n_fw = {r_wg[30:0], 1'b1};
                        n_wg = 32'd0;
                        n_gc = 3'd0;
                        have_bit = 1'b1;
                    end
                end else begin
                    b = r_fw[31];
                    n_fw = {r_fw[30:0], 1'b0};
                    have_bit = 1'b1;
                end
                if (have_bit) begin
                    case (r_phase)
                        PH_TOP: begin
                            if (b) begin
                                if (r_ended) begin
                                    n_err = ERR_TRUNC;
                                end else if (r_cnt >= i_cfg.limit) begin
                                    n_err = ERR_LIMIT;
                                end else begin
                                    n_phase = PH_LIT;
                                end
                            end else begin
                                n_off = 32'd1;
                                n_phase = PH_OFFA;
                            end
                        end
                        PH_OFFA, PH_OFFC: begin
                            if (r_off + 32'(b) > OFF_MAX) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_off = {r_off[30:0], b};
                                n_phase = (r_phase == PH_OFFA) ? PH_OFFB : PH_OFFA;
                            end
                        end
                        PH_OFFB: begin
                            if (!b) begin
                                if (is_de) begin
                                    n_off = r_off - 32'd1;
                                    n_phase = PH_OFFC;
                                end else begin
                                    n_phase = PH_OFFA;
                                end
                            end else if (r_off < 32'd3) begin
                                n_phase = is_e ? PH_ESEL : PH_LEN1;
                            end else if (r_ended) begin
                                n_err = ERR_TRUNC;
                            end else if ((offm3 & OFF_HI_MASK) != 32'd0) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_phase = PH_OFFBYTE;
                            end
                        end
                        PH_LEN1: begin
                            n_len = {31'd0, b};
                            n_phase = PH_LEN2;
                        end
                        PH_LEN2: begin
                            if ({r_len[30:0], b} == 32'd0) begin
                                n_len = 32'd1;
                                n_phase = PH_GAMA;
                            end else begin
                                n_fin = {r_len[30:0], b};
                                n_st = S_FIN;
                            end
                        end
                        PH_GAMA: begin
                            if (r_len + 32'(b) > LEN_MAX) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_len = {r_len[30:0], b};
                                n_phase = PH_GAMB;
                            end
                        end
                        PH_GAMB: begin
                            if (!b) begin
                                n_phase = PH_GAMA;
                            end else if (r_len > 32'hfffffffd) begin
                                n_err = ERR_OVF;
                            end else begin
                                n_fin = r_len + 32'd2;
                                n_st = S_FIN;
                            end
                        end
                        PH_ESEL: begin
                            if (b) begin
                                n_phase = PH_EONE;
                            end else begin
                                n_len = 32'd1;
                                n_phase = PH_ETWO;
                            end
                        end
                        PH_EONE: begin
                            n_fin = {31'd0, b};
                            n_st = S_FIN;
                        end
                        PH_ETWO: begin
                            n_phase = b ? PH_ETHREE : PH_GAMA;
                        end
                        PH_ETHREE: begin
                            n_fin = 32'd2 + 32'(b);
                            n_st = S_FIN;
                        end
                        default: begin
                            n_phase = PH_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                do_put = 1'b1;
                put_d = r_hq;
                n_copy = r_copy - 32'd1;
                n_st = S_RUN;
            end
            S_FIN: begin
                n_st = S_RUN;
                if (tot > 34'h0ffffffff) begin
                    n_err = ERR_OVF;
                end else if (!r_last[31]) begin
                    n_err = ERR_BADOF;
                end else if (mdist > WIN32) begin
                    n_err = ERR_WIN;
                end else if (mdist > r_cnt) begin
                    n_err = ERR_BADOF;
                end else if (34'(r_cnt) + tot > 34'(i_cfg.limit)) begin
                    n_err = ERR_LIMIT;
                end else begin
                    n_copy = tot[31:0];
                    n_phase = PH_TOP;
                end
            end
            S_EMRD: begin
                buf_re = 1'b1;
                n_st = S_EMWR;
            end
            S_EMWR: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_o.out_byte = (r_bn != '0) ? r_bq : 8'd0;
                    n_o.has_data = (r_bn != '0);
                    n_o.run_end = (r_k == nres - CW'(1));
                    n_o.copy_pending = (r_copy != 32'd0) && (r_err == ERR_NONE);
                    n_o.finished = (r_phase == PH_DONE);
                    n_o.error_code = r_err;
                    n_o.bytes_out = r_cnt;
                    if (r_k == nres - CW'(1)) begin
                        n_bn = '0;
                        n_st = S_IDLE;
                    end else begin
                        n_k = r_k + CW'(1);
                        n_st = S_EMRD;
                    end
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
        if (do_put) begin
            n_cnt = r_cnt + 32'd1;
            n_wptr = (r_wptr == WLAST) ? '0 : r_wptr + AW'(1);
            if (r_bn < BMAX) begin
                n_bn = r_bn + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_put) begin
            r_hist[r_wptr] <= put_d;
        end
        if (hist_re) begin
            r_hq <= r_hist[hist_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_put && r_bn < BMAX) begin
            r_buf[r_bn[BW-1:0]] <= put_d;
        end
        if (buf_re) begin
            r_bq <= r_buf[r_k[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o   <= n_o;
        r_fin <= n_fin;
        r_k   <= n_k;
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= PH_TOP;
            r_fw    <= 32'd0;
            r_wg    <= 32'd0;
            r_gc    <= 3'd0;
            r_last  <= ALL_ONES;
            r_copy  <= 32'd0;
            r_cnt   <= 32'd0;
            r_err   <= ERR_NONE;
            r_ended <= 1'b0;
            r_wptr  <= '0;
            r_ov    <= 1'b0;
            r_off   <= 32'd0;
            r_len   <= 32'd0;
            r_bn    <= '0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_fw    <= n_fw;
            r_wg    <= n_wg;
            r_gc    <= n_gc;
            r_last  <= n_last;
            r_copy  <= n_copy;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_ended <= n_ended;
            r_wptr  <= n_wptr;
            r_ov    <= n_ov;
            r_off   <= n_off;
            r_len   <= n_len;
            r_bn    <= n_bn;
        end
    end
endmodule
